// ===== rtl/ekr_pkg.sv =====
// ----------------------------------------------------------------------------
// ekr_pkg
// shared types, constants and the initial-consonant lookup for the
// euc-kr hangul initial extractor
// ----------------------------------------------------------------------------
package ekr_pkg;

  localparam int unsigned JAMO_RANGES = 19;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] HIGH_BIT_MIN = 8'h80;
  localparam logic [7:0] LEAD_MIN     = 8'hb0;
  localparam logic [7:0] LEAD_MAX     = 8'hc8;
  localparam logic [7:0] TRAIL_MIN    = 8'ha1;
  localparam logic [7:0] TRAIL_MAX    = 8'hfe;
  localparam logic [7:0] NO_LEAD      = 8'h00;
  localparam logic [7:0] NUL_BYTE     = 8'h00;

  // number of result bytes one input byte produces
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_ONE  = 2'd1,
    EMIT_TWO  = 2'd2
  } emit_cnt_t;

  // what the decoder hands to the output queue
  typedef struct packed {
    emit_cnt_t  cnt;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } push_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_entry_t;

  localparam logic [15:0] RANGE_START [JAMO_RANGES] = '{
    16'hb0a1, 16'hb1ee, 16'hb3aa, 16'hb4d9, 16'hb5fb, 16'hb6f3, 16'hb8b6,
    16'hb9d9, 16'hbafc, 16'hbbe7, 16'hbdce, 16'hbec6, 16'hc0da, 16'hc2a5,
    16'hc2f7, 16'hc4ab, 16'hc5b8, 16'hc6c4, 16'hc7cf
  };

  localparam logic [15:0] JAMO_CODE [JAMO_RANGES] = '{
    16'ha4a1, 16'ha4a2, 16'ha4a4, 16'ha4a7, 16'ha4a8, 16'ha4a9, 16'ha4b1,
    16'ha4b2, 16'ha4b3, 16'ha4b5, 16'ha4b6, 16'ha4b7, 16'ha4b8, 16'ha4b9,
    16'ha4ba, 16'ha4bb, 16'ha4bc, 16'ha4bd, 16'ha4be
  };

  // starts ascend, so the last range whose start is reached wins
  function automatic logic [15:0] map_initial(input logic [15:0] code);
    logic [15:0] res;
    res = code;
    for (int i = 0; i < JAMO_RANGES; i++) begin
      if (code >= RANGE_START[i]) begin
        res = JAMO_CODE[i];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/ekr_decode.sv =====
// ----------------------------------------------------------------------------
// ekr_decode
// per-byte decode: lead tracking, two-byte code forming and jamo mapping
// ----------------------------------------------------------------------------
module ekr_decode (
  input  logic          [7:0] byte_in,
  input  logic                sos,
  input  logic          [7:0] pending_lead,
  output logic          [7:0] pending_lead_next,
  output ekr_pkg::push_t      push
);
  import ekr_pkg::*;

  logic [7:0]  lead_eff;
  logic [15:0] code;
  logic        in_window;

  assign lead_eff  = sos ? NO_LEAD : pending_lead;
  assign in_window = (lead_eff >= LEAD_MIN) && (lead_eff <= LEAD_MAX) &&
                     (byte_in >= TRAIL_MIN) && (byte_in <= TRAIL_MAX);

  always_comb begin
    code = {lead_eff, byte_in};
    if (in_window) begin
      code = map_initial({lead_eff, byte_in});
    end
  end

  always_comb begin
    pending_lead_next = NO_LEAD;
    push.cnt          = EMIT_NONE;
    push.first_byte   = byte_in;
    push.second_byte  = code[7:0];
    if (byte_in < HIGH_BIT_MIN) begin
      // ascii drops any lead; nul emits nothing
      if (byte_in != NUL_BYTE) begin
        push.cnt = EMIT_ONE;
      end
    end else if (lead_eff == NO_LEAD) begin
      pending_lead_next = byte_in;
    end else begin
      push.cnt        = EMIT_TWO;
      push.first_byte = code[15:8];
    end
  end

endmodule

// ===== rtl/ekr_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ekr_out_fifo
// small output queue taking up to two bytes per cycle, giving one per cycle while not stalled
// ----------------------------------------------------------------------------
module ekr_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  ekr_pkg::push_t      push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output logic          [7:0] out_byte,
  output logic                last_of_run
);
  import ekr_pkg::*;

  out_entry_t             mem [FIFO_DEPTH];
  logic       [PTR_W-1:0] wr_ptr;
  logic       [PTR_W-1:0] wr_ptr_next;
  logic       [PTR_W-1:0] rd_ptr;
  logic       [CNT_W-1:0] count;
  logic       [CNT_W-1:0] count_next;
  logic       [1:0]       n_push;
  logic                   pop;
  out_entry_t             e0;
  out_entry_t             e1;

  assign room      = count <= CNT_W'(FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign n_push    = push_en ? push.cnt : EMIT_NONE;

  assign e0.data = push.first_byte;
  assign e0.last = push.cnt != EMIT_TWO;
  assign e1.data = push.second_byte;
  assign e1.last = 1'b1;

  assign wr_ptr_next = wr_ptr + PTR_W'(1);
  assign count_next  = count + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != EMIT_NONE) begin
      mem[wr_ptr] <= e0;
    end
    if (n_push == EMIT_TWO) begin
      mem[wr_ptr_next] <= e1;
    end
  end

  assign out_byte    = mem[rd_ptr].data;
  assign last_of_run = mem[rd_ptr].last;

endmodule

// ===== rtl/euckr_hangul_initial_extract.sv =====
// ----------------------------------------------------------------------------
// euckr_hangul_initial_extract
// euc-kr byte stream filter that replaces each hangul syllable by the
// compatibility jamo of its initial consonant
// ----------------------------------------------------------------------------
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, in_byte,         | in
//          | start_of_string                      |
//  out     | out_valid, out_stall, out_byte,      | out
//          | last_of_run                          |
//
// one input byte is taken per cycle unless stalled; a transfer on the input lands
// in an input register, is decoded from there and its 0..2 result bytes are
// written into a four-entry output queue once it has room. the queue gives
// one byte per cycle unless the output stalls.
// input stalls only while the queue has fewer than two free entries.
// synchronous active-high reset clears the lead byte, stage and queue.
module euckr_hangul_initial_extract (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       start_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import ekr_pkg::*;

  // input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sos;

  // lead byte waiting for its trail; zero means none
  logic [7:0] pending_lead;
  logic [7:0] pending_lead_next;

  push_t      push;
  logic       room;
  logic       advance;
  logic       in_xfer;

  // stage moves into the queue only when two entries are free
  assign advance  = s1_valid && room;
  assign in_stall = s1_valid && !room;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      pending_lead <= NO_LEAD;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        pending_lead <= pending_lead_next;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte <= in_byte;
      s1_sos  <= start_of_string;
    end
  end

  ekr_decode u_decode (
    .byte_in           (s1_byte),
    .sos               (s1_sos),
    .pending_lead      (pending_lead),
    .pending_lead_next (pending_lead_next),
    .push              (push)
  );

  ekr_out_fifo u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_en     (advance),
    .push        (push),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ===== dv/jamo_stream_checker.sv =====
// ----------------------------------------------------------------------------
// jamo_stream_checker
// watches both channels of the euc-kr initial extractor, predicts the text
// bytes every input transfer causes and compares them in order with the
// output transfers
// ----------------------------------------------------------------------------
module jamo_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       start_of_string,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       last_of_run,
  output int         errors,
  output int         bytes_due
);
  import ekr_pkg::*;

  // first code of each initial-consonant range, entry 0 in the low bits
  localparam logic [JAMO_RANGES*16-1:0] SYL_FIRST = {
    16'hc7cf, 16'hc6c4, 16'hc5b8, 16'hc4ab, 16'hc2f7, 16'hc2a5, 16'hc0da,
    16'hbec6, 16'hbdce, 16'hbbe7, 16'hbafc, 16'hb9d9, 16'hb8b6, 16'hb6f3,
    16'hb5fb, 16'hb4d9, 16'hb3aa, 16'hb1ee, 16'hb0a1
  };

  // compatibility jamo of each range, same order
  localparam logic [JAMO_RANGES*16-1:0] JAMO_OF = {
    16'ha4be, 16'ha4bd, 16'ha4bc, 16'ha4bb, 16'ha4ba, 16'ha4b9, 16'ha4b8,
    16'ha4b7, 16'ha4b6, 16'ha4b5, 16'ha4b3, 16'ha4b2, 16'ha4b1, 16'ha4a9,
    16'ha4a8, 16'ha4a7, 16'ha4a4, 16'ha4a2, 16'ha4a1
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  text_byte_t text_bytes_q [$];
  logic [7:0] lead_byte;
  int         err_cnt = 0;

  assign errors = err_cnt;

  // the number of range starts a code reaches picks its jamo
  function automatic logic [15:0] initial_jamo(input logic [15:0] code);
    int reached;
    reached = 0;
    for (int k = 0; k < JAMO_RANGES; k++) begin
      if (code >= SYL_FIRST[k*16 +: 16]) reached++;
    end
    return (reached == 0) ? code : JAMO_OF[(reached-1)*16 +: 16];
  endfunction

  task automatic push_text_byte(input logic [7:0] data, input logic last);
    text_byte_t tb;
    tb.data = data;
    tb.last = last;
    text_bytes_q.push_back(tb);
  endtask

  task automatic predict_text_bytes(input logic [7:0] b, input logic sos);
    logic [15:0] code;
    if (sos) lead_byte = NO_LEAD;
    if (b < HIGH_BIT_MIN) begin
      lead_byte = NO_LEAD;
      if (b != NUL_BYTE) push_text_byte(b, 1'b1);
    end else if (lead_byte == NO_LEAD) begin
      lead_byte = b;
    end else begin
      code = {lead_byte, b};
      if (lead_byte >= LEAD_MIN && lead_byte <= LEAD_MAX &&
          b >= TRAIL_MIN && b <= TRAIL_MAX) begin
        code = initial_jamo(code);
      end
      lead_byte = NO_LEAD;
      push_text_byte(code[15:8], 1'b0);
      push_text_byte(code[7:0], 1'b1);
    end
  endtask

  always @(posedge clk) begin
    text_byte_t want;
    if (rst) begin
      lead_byte = NO_LEAD;
      text_bytes_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_text_bytes(in_byte, start_of_string);
      if (out_valid && !out_stall) begin
        if (text_bytes_q.size() == 0) begin
          $error("out_byte: expected none, got %h", out_byte);
          err_cnt++;
        end else begin
          want = text_bytes_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            err_cnt++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, last_of_run);
            err_cnt++;
          end
        end
      end
    end
    bytes_due <= text_bytes_q.size();
  end

endmodule

// ===== dv/euckr_hangul_initial_extract_tb.sv =====
// ----------------------------------------------------------------------------
// euckr_hangul_initial_extract_tb
// drives euc-kr text into the initial extractor: a directed run over the
// range edges and special cases, then random well-formed hangul, ascii and
// other two-byte text mixed with noise, with random gaps and stalls on both
// sides; the checker predicts and compares every output transfer
// ----------------------------------------------------------------------------
module euckr_hangul_initial_extract_tb;

  localparam int TOTAL_BYTES = 1250;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       start_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  int errors;
  int bytes_due;
  int bytes_sent = 0;
  int cycle_cnt = 0;
  // while set, neither side idles or stalls
  bit quiet = 1'b0;

  euckr_hangul_initial_extract u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .start_of_string (start_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .last_of_run     (last_of_run)
  );

  jamo_stream_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .start_of_string (start_of_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .last_of_run     (last_of_run),
    .errors          (errors),
    .bytes_due       (bytes_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // idle cycles before a transfer: none while quiet or half the time, else random
  function automatic int pick_gap();
    if (quiet) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
  endfunction

  // one input transfer; valid drops only when a gap is drawn, so back-to-back
  // bytes keep it high without a second assignment in the same step
  task automatic send_byte(input logic [7:0] b, input logic sos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    start_of_string <= sos;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // stop sending until the checker holds no more expected bytes; the
  // checker's count is registered, hence the extra wait first
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
  endtask

  // receiver: stall a random number of cycles before each output transfer
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int  pick;
    bit  sos;
    bit  paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ascii echo of a letter and of the top code, null dropped
    send_byte(8'h41, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    // first syllable of the window and the last one
    send_byte(8'hb0, 1'b0);
    send_byte(8'ha1, 1'b0);
    send_byte(8'hc8, 1'b0);
    send_byte(8'hfe, 1'b0);
    // either side of a range boundary
    send_byte(8'hb1, 1'b0);
    send_byte(8'hed, 1'b0);
    send_byte(8'hb1, 1'b0);
    send_byte(8'hee, 1'b0);
    // lead just below the window passes through
    send_byte(8'haf, 1'b0);
    send_byte(8'ha1, 1'b0);
    // trail just below and just above the window pass through
    send_byte(8'hb0, 1'b0);
    send_byte(8'ha0, 1'b0);
    send_byte(8'hc8, 1'b0);
    send_byte(8'hff, 1'b0);
    // lead dropped by a low byte, which is echoed alone
    send_byte(8'hb0, 1'b0);
    send_byte(8'h41, 1'b0);
    // lead dropped by a null, nothing out
    send_byte(8'hc0, 1'b0);
    send_byte(8'h00, 1'b0);
    // start of string discards the lead; the new byte becomes the lead
    send_byte(8'hb5, 1'b0);
    send_byte(8'ha1, 1'b1);
    send_byte(8'hc7, 1'b0);
    hold_until_drained();

    while (bytes_sent < TOTAL_BYTES) begin
      // every fourth stretch of about a hundred bytes runs with no idling
      quiet = ((bytes_sent / 100) % 4) == 2;
      // halfway through, let the block empty completely once
      if (!paused && bytes_sent >= TOTAL_BYTES / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      sos = ($urandom_range(0, 15) == 0);
      if (pick < 45) begin
        // hangul syllable
        send_byte(8'($urandom_range(8'hb0, 8'hc8)), sos);
        send_byte(8'($urandom_range(8'ha1, 8'hfe)), 1'b0);
      end else if (pick < 65) begin
        send_byte(8'($urandom_range(1, 127)), sos);
      end else if (pick < 77) begin
        // any two-byte code, hangul range included
        send_byte(8'($urandom_range(128, 255)), sos);
        send_byte(8'($urandom_range(128, 255)), 1'b0);
      end else if (pick < 90) begin
        send_byte(8'($urandom), 1'($urandom));
      end else if (pick < 94) begin
        send_byte(8'h00, sos);
      end else begin
        // orphan lead, shifts the pairing until a low byte or start of string resyncs it
        send_byte(8'($urandom_range(128, 255)), sos);
      end
    end

    quiet = 1'b0;
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && bytes_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ekr_pkg.sv
rtl/ekr_decode.sv
rtl/ekr_out_fifo.sv
rtl/euckr_hangul_initial_extract.sv
dv/jamo_stream_checker.sv
dv/euckr_hangul_initial_extract_tb.sv
